@@ design/mdpm_pkg.sv @@
// ----------------------------------------------------------------------------
// mdpm_pkg: shared types and codes for the multi-deque pool manager
// Holds the request and status codes, the controller states, the datapath
// micro-operations and the command and status bundles that join the two.
// ----------------------------------------------------------------------------
package mdpm_pkg;

  localparam int DEF_NUM_QUEUES = 1024;
  localparam int DEF_POOL_SIZE  = 4096;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int CFG_W   = 11;
  localparam int QID_W   = 10;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int FUNC_W  = 2;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MERGE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_BADQ  = 2'd3;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CHECK, S_CLR, S_CAPA, S_PU_CHK, S_PU_TAKE, S_PU_WR1,
    S_PU_WR2, S_PO_CHK, S_PO_WR, S_PO_FREE, S_CAPB, S_MG_CHK, S_MS_RD,
    S_MS_GIVE, S_MR_RD, S_MR_SWAP, S_MG_LINK, S_MG_CLRB, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SWEEP, OP_RDA, OP_CAPA, OP_CAPB, OP_PU_RD,
    OP_PU_TAKE, OP_PU_WR1, OP_PU_WR2, OP_PO_RD, OP_PO_WR, OP_PO_FREE,
    OP_MS_INIT, OP_MR_INIT, OP_W_RD, OP_MS_GIVE, OP_MS_END, OP_MR_SWAP,
    OP_MG_LINK, OP_MG_CLRB, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic            set_st;
    logic [ST_W-1:0] st;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              sel;
    logic              bad;
    logic              same;
    logic              hb_nil;
    logic              fh_nil;
    logic              cur_nil;
    logic              pop_nil;
    logic              sweep_last;
    logic              out_free;
  } dp_stat_t;

endpackage

@@ design/mdpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mdpm_ctrl: request sequencer
// Steps each request through its memory reads, link updates and node walks,
// one datapath micro-operation per cycle unless its result cannot be placed.
// ----------------------------------------------------------------------------
module mdpm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output mdpm_pkg::cmd_t     cmd,
  input  mdpm_pkg::dp_stat_t stat
);
  import mdpm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:    if (stat.sweep_last) state_nxt = S_IDLE;
      S_IDLE:    if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (stat.func == FUNC_CLEAR) state_nxt = S_CLR;
        else if (stat.bad) state_nxt = S_DONE;
        else state_nxt = S_CAPA;
      end
      S_CLR:     if (stat.sweep_last) state_nxt = S_DONE;
      S_CAPA: begin
        case (stat.func)
          FUNC_PUSH: state_nxt = S_PU_CHK;
          FUNC_POP:  state_nxt = S_PO_CHK;
          default:   state_nxt = S_CAPB;
        endcase
      end
      S_PU_CHK:  state_nxt = stat.fh_nil ? S_DONE : S_PU_TAKE;
      S_PU_TAKE: state_nxt = S_PU_WR1;
      S_PU_WR1:  state_nxt = S_PU_WR2;
      S_PU_WR2:  state_nxt = S_DONE;
      S_PO_CHK:  state_nxt = stat.pop_nil ? S_DONE : S_PO_WR;
      S_PO_WR:   state_nxt = S_PO_FREE;
      S_PO_FREE: state_nxt = S_DONE;
      S_CAPB:    state_nxt = S_MG_CHK;
      S_MG_CHK: begin
        if (stat.same) state_nxt = S_MS_RD;
        else if (stat.hb_nil) state_nxt = S_DONE;
        else if (stat.sel) state_nxt = S_MR_RD;
        else state_nxt = S_MG_LINK;
      end
      S_MS_RD:   state_nxt = stat.cur_nil ? S_DONE : S_MS_GIVE;
      S_MS_GIVE: state_nxt = S_MS_RD;
      S_MR_RD:   state_nxt = stat.cur_nil ? S_MG_LINK : S_MR_SWAP;
      S_MR_SWAP: state_nxt = S_MR_RD;
      S_MG_LINK: state_nxt = S_MG_CLRB;
      S_MG_CLRB: state_nxt = S_DONE;
      S_DONE:    if (stat.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.set_st = 1'b0;
    cmd.st     = ST_OK;
    in_tready  = 1'b0;
    unique case (state_r)
      S_INIT, S_CLR: cmd.op = OP_SWEEP;
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      S_CHECK: begin
        if (stat.func == FUNC_CLEAR) begin
          cmd.op = OP_NONE;
        end else if (stat.bad) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_BADQ;
        end else begin
          cmd.op = OP_RDA;
        end
      end
      S_CAPA: cmd.op = OP_CAPA;
      S_PU_CHK: begin
        if (stat.fh_nil) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_FULL;
        end else begin
          cmd.op = OP_PU_RD;
        end
      end
      S_PU_TAKE: cmd.op = OP_PU_TAKE;
      S_PU_WR1:  cmd.op = OP_PU_WR1;
      S_PU_WR2:  cmd.op = OP_PU_WR2;
      S_PO_CHK: begin
        if (stat.pop_nil) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_EMPTY;
        end else begin
          cmd.op = OP_PO_RD;
        end
      end
      S_PO_WR:   cmd.op = OP_PO_WR;
      S_PO_FREE: cmd.op = OP_PO_FREE;
      S_CAPB:    cmd.op = OP_CAPB;
      S_MG_CHK: begin
        if (stat.same) cmd.op = OP_MS_INIT;
        else if (!stat.hb_nil && stat.sel) cmd.op = OP_MR_INIT;
      end
      S_MS_RD:   cmd.op = stat.cur_nil ? OP_MS_END : OP_W_RD;
      S_MS_GIVE: cmd.op = OP_MS_GIVE;
      S_MR_RD:   if (!stat.cur_nil) cmd.op = OP_W_RD;
      S_MR_SWAP: cmd.op = OP_MR_SWAP;
      S_MG_LINK: cmd.op = OP_MG_LINK;
      S_MG_CLRB: cmd.op = OP_MG_CLRB;
      S_DONE:    if (stat.out_free) cmd.op = OP_EMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

  // A result is only ever finished from the final state of a request.
  a_emit_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (state_r == S_DONE && stat.out_free))
    else $error("result emitted outside the done state");
  // Input is taken only at rest, and a load moves on to the check state.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |=> (state_r == S_CHECK))
    else $error("request load did not move to the check state");
  // A node walk step always alternates a read with its write-back.
  a_walk_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MS_GIVE || state_r == S_MR_SWAP) |-> ($past(cmd.op) == OP_W_RD))
    else $error("walk write-back without a preceding node read");

endmodule

@@ design/mdpm_datapath.sv @@
// ----------------------------------------------------------------------------
// mdpm_datapath: queue tables, node pool and result register
// Holds the head/tail tables, the node link and data memories, the free
// list pointers, the queue-count register and the output item register.
// ----------------------------------------------------------------------------
module mdpm_datapath #(
  parameter int NUM_QUEUES = mdpm_pkg::DEF_NUM_QUEUES,
  parameter int POOL_SIZE  = mdpm_pkg::DEF_POOL_SIZE,
  parameter int DATA_WIDTH = mdpm_pkg::DEF_DATA_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mdpm_pkg::cmd_t              cmd,
  output mdpm_pkg::dp_stat_t          stat,
  input  logic [55:0]                 in_tdata,
  input  logic [2:0]                  in_tuser,
  input  logic                        cfg_wr_en,
  input  logic [mdpm_pkg::CFG_W-1:0]  cfg_wr_data,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,
  output logic [1:0]                  out_tuser
);
  import mdpm_pkg::*;

  localparam int NW = $clog2(POOL_SIZE + 1);
  localparam int AW = $clog2(POOL_SIZE);
  localparam int QW = $clog2(NUM_QUEUES);
  localparam logic [NW-1:0] NIL = NW'(POOL_SIZE);

  logic [FUNC_W-1:0] func_r, func_nxt;
  logic              sel_r, sel_nxt;
  logic [QID_W-1:0]  qa_r, qa_nxt, qb_r, qb_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [NW-1:0]     ha_r, ha_nxt, ta_r, ta_nxt, hb_r, hb_nxt, tb_r, tb_nxt;
  logic [NW-1:0]     fh_r, fh_nxt, bump_r, bump_nxt, n_r, n_nxt, cur_r, cur_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [VAL_W-1:0]  pv_r, pv_nxt;
  logic [QW-1:0]     sw_r, sw_nxt;
  logic [CFG_W-1:0]  cfg_r;
  logic              ov_r, ov_nxt;
  logic [ST_W-1:0]   ost_r, ost_nxt;
  logic [VAL_W-1:0]  opv_r, opv_nxt;

  logic [NW-1:0]         qhead_mem [NUM_QUEUES];
  logic [NW-1:0]         qtail_mem [NUM_QUEUES];
  logic [NW-1:0]         nnext_mem [POOL_SIZE];
  logic [NW-1:0]         nprev_mem [POOL_SIZE];
  logic [DATA_WIDTH-1:0] ndata_mem [POOL_SIZE];
  logic [NW-1:0]         qh_rd, qt_rd, nn_rd, np_rd;
  logic [DATA_WIDTH-1:0] nd_rd;

  logic                  q_re, n_re;
  logic [QW-1:0]         q_raddr;
  logic [AW-1:0]         n_raddr;
  logic                  qh_we, qt_we, nn_we, np_we, nd_we;
  logic [QW-1:0]         qh_wa, qt_wa;
  logic [AW-1:0]         nn_wa, np_wa, nd_wa;
  logic [NW-1:0]         qh_wd, qt_wd, nn_wd, np_wd;
  logic [DATA_WIDTH-1:0] nd_wd;

  logic [QW-1:0] qa_a, qb_a;
  logic [31:0]   cfg32, lim;
  logic [NW-1:0] pop_n, hv, tv;
  logic [63:0]   val64, nd64;
  logic          sweep_last;

  assign qa_a       = QW'(qa_r);
  assign qb_a       = QW'(qb_r);
  assign cfg32      = 32'(cfg_r);
  assign lim        = (cfg32 > 32'(NUM_QUEUES)) ? 32'(NUM_QUEUES) : cfg32;
  assign pop_n      = sel_r ? ta_r : ha_r;
  assign hv         = sel_r ? tb_r : hb_r;
  assign tv         = sel_r ? hb_r : tb_r;
  assign val64      = 64'(val_r);
  assign nd64       = 64'(nd_rd);
  assign sweep_last = (sw_r == QW'(NUM_QUEUES - 1));

  always_comb begin
    stat.func       = func_r;
    stat.sel        = sel_r;
    stat.bad        = (32'(qa_r) >= lim) || (func_r == FUNC_MERGE && 32'(qb_r) >= lim);
    stat.same       = (qa_r == qb_r);
    stat.hb_nil     = (hb_r == NIL);
    stat.fh_nil     = (fh_r == NIL);
    stat.cur_nil    = (cur_r == NIL);
    stat.pop_nil    = (pop_n == NIL);
    stat.sweep_last = sweep_last;
    stat.out_free   = !ov_r || out_tready;
  end

  always_comb begin
    func_nxt = func_r; sel_nxt = sel_r; qa_nxt = qa_r; qb_nxt = qb_r;
    val_nxt = val_r; ha_nxt = ha_r; ta_nxt = ta_r; hb_nxt = hb_r; tb_nxt = tb_r;
    fh_nxt = fh_r; bump_nxt = bump_r; n_nxt = n_r; cur_nxt = cur_r;
    st_nxt = st_r; pv_nxt = pv_r; sw_nxt = sw_r;
    ov_nxt = ov_r && !out_tready; ost_nxt = ost_r; opv_nxt = opv_r;
    q_re = 1'b0; q_raddr = qa_a; n_re = 1'b0; n_raddr = AW'(cur_r);
    qh_we = 1'b0; qh_wa = qa_a; qh_wd = NIL;
    qt_we = 1'b0; qt_wa = qa_a; qt_wd = NIL;
    nn_we = 1'b0; nn_wa = AW'(n_r); nn_wd = NIL;
    np_we = 1'b0; np_wa = AW'(n_r); np_wd = NIL;
    nd_we = 1'b0; nd_wa = AW'(n_r); nd_wd = val64[DATA_WIDTH-1:0];
    case (cmd.op)
      OP_LOAD: begin
        func_nxt = in_tuser[1:0];
        sel_nxt  = in_tuser[2];
        qa_nxt   = in_tdata[9:0];
        qb_nxt   = in_tdata[19:10];
        val_nxt  = in_tdata[51:20];
        st_nxt   = ST_OK;
        pv_nxt   = '0;
      end
      OP_SWEEP: begin
        qh_we = 1'b1; qh_wa = sw_r;
        qt_we = 1'b1; qt_wa = sw_r;
        sw_nxt   = sweep_last ? '0 : sw_r + 1'b1;
        fh_nxt   = '0;
        bump_nxt = '0;
      end
      OP_RDA: begin
        q_re = 1'b1; q_raddr = qa_a;
      end
      OP_CAPA: begin
        ha_nxt = qh_rd; ta_nxt = qt_rd;
        q_re = 1'b1; q_raddr = qb_a;
      end
      OP_CAPB: begin
        hb_nxt = qh_rd; tb_nxt = qt_rd;
      end
      OP_PU_RD: begin
        n_re = 1'b1; n_raddr = AW'(fh_r);
      end
      OP_PU_TAKE: begin
        // Nodes at or above the bump mark were never used and chain in order.
        n_nxt = fh_r;
        if (fh_r == bump_r) begin
          fh_nxt   = fh_r + 1'b1;
          bump_nxt = bump_r + 1'b1;
        end else begin
          fh_nxt = nn_rd;
        end
      end
      OP_PU_WR1: begin
        nd_we = 1'b1;
        np_we = 1'b1; np_wd = sel_r ? ta_r : NIL;
        nn_we = 1'b1; nn_wd = sel_r ? NIL : ha_r;
      end
      OP_PU_WR2: begin
        if (sel_r) begin
          if (ta_r != NIL) begin
            nn_we = 1'b1; nn_wa = AW'(ta_r); nn_wd = n_r;
          end else begin
            qh_we = 1'b1; qh_wd = n_r;
          end
          qt_we = 1'b1; qt_wd = n_r;
        end else begin
          if (ha_r != NIL) begin
            np_we = 1'b1; np_wa = AW'(ha_r); np_wd = n_r;
          end else begin
            qt_we = 1'b1; qt_wd = n_r;
          end
          qh_we = 1'b1; qh_wd = n_r;
        end
      end
      OP_PO_RD: begin
        n_nxt = pop_n;
        n_re = 1'b1; n_raddr = AW'(pop_n);
      end
      OP_PO_WR: begin
        if (sel_r) begin
          qt_we = 1'b1; qt_wd = np_rd;
          if (np_rd != NIL) begin
            nn_we = 1'b1; nn_wa = AW'(np_rd);
          end else begin
            qh_we = 1'b1;
          end
        end else begin
          qh_we = 1'b1; qh_wd = nn_rd;
          if (nn_rd != NIL) begin
            np_we = 1'b1; np_wa = AW'(nn_rd);
          end else begin
            qt_we = 1'b1;
          end
        end
      end
      OP_PO_FREE: begin
        nn_we = 1'b1; nn_wd = fh_r;
        fh_nxt = n_r;
        pv_nxt = nd64[VAL_W-1:0];
      end
      OP_MS_INIT: cur_nxt = ha_r;
      OP_MR_INIT: cur_nxt = hb_r;
      OP_W_RD: begin
        n_re = 1'b1; n_raddr = AW'(cur_r);
      end
      OP_MS_GIVE: begin
        nn_we = 1'b1; nn_wa = AW'(cur_r); nn_wd = fh_r;
        fh_nxt  = cur_r;
        cur_nxt = nn_rd;
      end
      OP_MS_END: begin
        qh_we = 1'b1; qt_we = 1'b1;
      end
      OP_MR_SWAP: begin
        nn_we = 1'b1; nn_wa = AW'(cur_r); nn_wd = np_rd;
        np_we = 1'b1; np_wa = AW'(cur_r); np_wd = nn_rd;
        cur_nxt = nn_rd;
      end
      OP_MG_LINK: begin
        np_we = 1'b1; np_wa = AW'(hv);
        if (ta_r != NIL) begin
          nn_we = 1'b1; nn_wa = AW'(ta_r); nn_wd = hv;
          np_wd = ta_r;
        end else begin
          qh_we = 1'b1; qh_wd = hv;
        end
        qt_we = 1'b1; qt_wd = tv;
      end
      OP_MG_CLRB: begin
        qh_we = 1'b1; qh_wa = qb_a;
        qt_we = 1'b1; qt_wa = qb_a;
      end
      OP_EMIT: begin
        ov_nxt  = 1'b1;
        ost_nxt = st_r;
        opv_nxt = pv_r;
      end
      default: begin
      end
    endcase
    if (cmd.set_st) st_nxt = cmd.st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r  <= '0;
      ov_r  <= 1'b0;
      cfg_r <= CFG_RESET;
    end else begin
      sw_r <= sw_nxt;
      ov_r <= ov_nxt;
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt; sel_r <= sel_nxt; qa_r <= qa_nxt; qb_r <= qb_nxt;
    val_r <= val_nxt; ha_r <= ha_nxt; ta_r <= ta_nxt; hb_r <= hb_nxt;
    tb_r <= tb_nxt; fh_r <= fh_nxt; bump_r <= bump_nxt; n_r <= n_nxt;
    cur_r <= cur_nxt; st_r <= st_nxt; pv_r <= pv_nxt;
    ost_r <= ost_nxt; opv_r <= opv_nxt;
  end

  always_ff @(posedge clk) begin
    if (qh_we) qhead_mem[qh_wa] <= qh_wd;
    if (q_re) qh_rd <= qhead_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (qt_we) qtail_mem[qt_wa] <= qt_wd;
    if (q_re) qt_rd <= qtail_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (nn_we) nnext_mem[nn_wa] <= nn_wd;
    if (n_re) nn_rd <= nnext_mem[n_raddr];
  end

  always_ff @(posedge clk) begin
    if (np_we) nprev_mem[np_wa] <= np_wd;
    if (n_re) np_rd <= nprev_mem[n_raddr];
  end

  always_ff @(posedge clk) begin
    if (nd_we) ndata_mem[nd_wa] <= nd_wd;
    if (n_re) nd_rd <= ndata_mem[n_raddr];
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = opv_r;
  assign out_tuser  = ost_r;

  // The free list head is an explicitly freed node, the bump mark or null.
  a_fh_le_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_SWEEP && $past(cmd.op) != OP_SWEEP && $past(rst_n)) |->
      (fh_r <= bump_r || fh_r == NIL))
    else $error("free list head beyond the bump mark");
  a_bump_range: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.op) == OP_PU_TAKE) |-> (bump_r <= NIL))
    else $error("bump mark past the end of the pool");
  a_pop_ok_value: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT && st_r != ST_OK) |-> (pv_r == '0))
    else $error("nonzero pop value on a failed request");

endmodule

@@ design/multi_deque_pool_manager.sv @@
// ----------------------------------------------------------------------------
// multi_deque_pool_manager: many deques sharing one linked node pool
// Push, pop, merge (in order or reversed) and clear-all on double-ended
// queues built from a shared pool of doubly linked nodes.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake              Payload
// in       slave      in_tvalid/in_tready    tdata: queue_id, other_queue, value
//                                            tuser: func, end_sel
// out      master     out_tvalid/out_tready  tdata: pop_value; tuser: status
// cfg      write      cfg_wr_en              cfg_wr_data: queues_in_use
//
// One request is worked at a time, with a single read and write port on
// each memory. A merge into itself and a reversed merge walk the source
// node by node, and clear sweeps the head and tail tables of every queue.
// After reset the head and tail tables are swept to null, one queue per
// cycle, and no item is accepted until that ends.
// A finished result waits in the output register; the next item is taken
// meanwhile, and a request only stalls when its own result cannot be placed.
module multi_deque_pool_manager #(
  parameter int NUM_QUEUES = mdpm_pkg::DEF_NUM_QUEUES,
  parameter int POOL_SIZE  = mdpm_pkg::DEF_POOL_SIZE,
  parameter int DATA_WIDTH = mdpm_pkg::DEF_DATA_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // queue_id [9:0], other_queue [19:10], value [51:20], zero fill [55:52]
  input  logic [55:0]                in_tdata,
  // func [1:0], end_sel [2]
  input  logic [2:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // pop_value [31:0]
  output logic [31:0]                out_tdata,
  // status [1:0]
  output logic [1:0]                 out_tuser,
  input  logic                       cfg_wr_en,
  input  logic [mdpm_pkg::CFG_W-1:0] cfg_wr_data
);
  import mdpm_pkg::*;

  // The sequencer drives one micro-operation each cycle while not stalled
  // and reads back the pointer and handshake flags it branches on.
  cmd_t     cmd;
  dp_stat_t stat;

  mdpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mdpm_datapath #(
    .NUM_QUEUES (NUM_QUEUES),
    .POOL_SIZE  (POOL_SIZE),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream bench for the multi-deque pool manager
// Drives push, pop, merge and clear requests with random idling on both
// channels and checks every status and popped value against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import mdpm_pkg::*;

  localparam int NQ     = 1024;
  localparam int NP     = 4096;
  localparam int NIL    = NP;
  localparam int WD_MAX = 20000;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  qa;
    logic [9:0]  qb;
    logic        sel;
    logic [31:0] val;
  } req_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] pv;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  multi_deque_pool_manager i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state: a private copy of the linked pool.
  int          pq_head[NQ];
  int          pq_tail[NQ];
  logic [31:0] pn_data[NP];
  int          pn_next[NP];
  int          pn_prev[NP];
  int          free_head;
  int          free_cnt;
  int          qcount;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int  errors = 0;
  int  accepted_in = 0;
  int  accepted_out = 0;
  int  wd_count = 0;
  bit  quiet = 1'b0;
  bit  stim_done = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  n_pop_ok = 0;
  int  n_full = 0;
  int  n_badq = 0;

  function automatic void pool_rebuild();
    for (int i = 0; i < NQ; i++) begin
      pq_head[i] = NIL;
      pq_tail[i] = NIL;
    end
    for (int i = 0; i < NP; i++) begin
      pn_next[i] = i + 1;
      pn_prev[i] = NIL;
    end
    free_head = 0;
    free_cnt = NP;
  endfunction

  function automatic void node_release(int n);
    pn_next[n] = free_head;
    free_head = n;
    free_cnt++;
  endfunction

  // Works out the response of one request and updates the pool copy.
  function automatic rsp_t deque_apply(req_t r);
    rsp_t o;
    int lim, n, t, h, cur, nx, hv, tv;
    o.st = ST_OK;
    o.pv = '0;
    lim = (qcount > NQ) ? NQ : qcount;
    if (r.func == FUNC_CLEAR) begin
      pool_rebuild();
    end else if (r.qa >= lim || (r.func == FUNC_MERGE && r.qb >= lim)) begin
      o.st = ST_BADQ;
    end else if (r.func == FUNC_PUSH) begin
      if (free_cnt == 0 || free_head >= NP) begin
        o.st = ST_FULL;
      end else begin
        n = free_head;
        free_head = pn_next[n];
        free_cnt--;
        pn_data[n] = r.val;
        if (r.sel) begin
          t = pq_tail[r.qa];
          pn_next[n] = NIL;
          pn_prev[n] = t;
          if (t < NP) pn_next[t] = n; else pq_head[r.qa] = n;
          pq_tail[r.qa] = n;
        end else begin
          h = pq_head[r.qa];
          pn_prev[n] = NIL;
          pn_next[n] = h;
          if (h < NP) pn_prev[h] = n; else pq_tail[r.qa] = n;
          pq_head[r.qa] = n;
        end
      end
    end else if (r.func == FUNC_POP) begin
      n = r.sel ? pq_tail[r.qa] : pq_head[r.qa];
      if (n >= NP) begin
        o.st = ST_EMPTY;
      end else begin
        o.pv = pn_data[n];
        if (r.sel) begin
          t = pn_prev[n];
          pq_tail[r.qa] = t;
          if (t < NP) pn_next[t] = NIL; else pq_head[r.qa] = NIL;
        end else begin
          h = pn_next[n];
          pq_head[r.qa] = h;
          if (h < NP) pn_prev[h] = NIL; else pq_tail[r.qa] = NIL;
        end
        node_release(n);
      end
    end else if (r.qa == r.qb) begin
      // Merging a queue into itself frees all of its nodes.
      cur = pq_head[r.qa];
      while (cur < NP) begin
        nx = pn_next[cur];
        node_release(cur);
        cur = nx;
      end
      pq_head[r.qa] = NIL;
      pq_tail[r.qa] = NIL;
    end else if (pq_head[r.qb] < NP) begin
      if (r.sel) begin
        cur = pq_head[r.qb];
        while (cur < NP) begin
          nx = pn_next[cur];
          pn_next[cur] = pn_prev[cur];
          pn_prev[cur] = nx;
          cur = nx;
        end
        hv = pq_tail[r.qb];
        tv = pq_head[r.qb];
      end else begin
        hv = pq_head[r.qb];
        tv = pq_tail[r.qb];
      end
      if (pq_tail[r.qa] < NP) begin
        pn_next[pq_tail[r.qa]] = hv;
        pn_prev[hv] = pq_tail[r.qa];
      end else begin
        pq_head[r.qa] = hv;
        pn_prev[hv] = NIL;
      end
      pq_tail[r.qa] = tv;
      pq_head[r.qb] = NIL;
      pq_tail[r.qb] = NIL;
    end
    return o;
  endfunction

  function automatic req_t mk_req(logic [1:0] f, int a, int b, bit s, logic [31:0] v);
    req_t r;
    r.func = f;
    r.qa = a[9:0];
    r.qb = b[9:0];
    r.sel = s;
    r.val = v;
    return r;
  endfunction

  // Appends one request to the pending list.
  function automatic void add_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  // Random request over a small set of queues so that they actually fill.
  function automatic req_t rand_req(int span);
    req_t r;
    int k;
    k = $urandom_range(0, 99);
    r.qa = 10'($urandom_range(0, span - 1));
    r.qb = 10'($urandom_range(0, span - 1));
    r.sel = 1'($urandom_range(0, 1));
    r.val = $urandom;
    if (k < 50) r.func = FUNC_PUSH;
    else if (k < 85) r.func = FUNC_POP;
    else if (k < 98) r.func = FUNC_MERGE;
    else r.func = FUNC_CLEAR;
    // A few requests use any queue number to hit the upper id bits.
    if ($urandom_range(0, 19) == 0) r.qa = 10'($urandom);
    if ($urandom_range(0, 19) == 0) r.qb = 10'($urandom);
    return r;
  endfunction

  // Driver: presents the oldest pending item, with random idle bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_rsps = {expected_rsps, deque_apply(pending_reqs[0])};
        pending_reqs.delete(0);
        accepted_in++;
      end
      if (in_tvalid && !in_tready) begin
        // Hold the item until it is taken.
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(1, 18);
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_t nx;
        nx = pending_reqs[0];
        in_tvalid <= 1'b1;
        in_tdata <= {4'b0, nx.val, nx.qb, nx.qa};
        in_tuser <= {nx.sel, nx.func};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        accepted_out++;
        if (expected_rsps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result st=%0d pv=%h", out_tuser, out_tdata);
        end else begin
          rsp_t e;
          e = expected_rsps[0];
          expected_rsps.delete(0);
          if (e.st == ST_OK && out_tdata != 0) n_pop_ok++;
          if (e.st == ST_FULL) n_full++;
          if (e.st == ST_BADQ) n_badq++;
          if (out_tuser !== e.st || out_tdata !== e.pv) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st=%0d pv=%h, got st=%0d pv=%h",
                       e.st, e.pv, out_tuser, out_tdata);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 18);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: the head-table sweep and a long clear fit well below the limit.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wd_count <= 0;
      else if (pending_reqs.size() != 0 || expected_rsps.size() != 0) wd_count <= wd_count + 1;
      if (wd_count >= WD_MAX) begin
        $display("watchdog expired");
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_qcount(int v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[CFG_W-1:0];
    qcount = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(int cnt, int span);
    for (int i = 0; i < cnt; i++) add_req(rand_req(span));
    drain();
  endtask

  initial begin
    qcount = CFG_RESET;
    pool_rebuild();
    for (int i = 0; i < NP; i++) pn_data[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, each operation and the special cases.
    add_req(mk_req(FUNC_POP, 0, 0, 0, 0));             // empty pop
    add_req(mk_req(FUNC_PUSH, 0, 0, 0, 32'h8000_0000));
    add_req(mk_req(FUNC_PUSH, 0, 0, 1, 32'h7fff_ffff));
    add_req(mk_req(FUNC_PUSH, 1023, 1023, 1, 32'hffff_ffff));
    add_req(mk_req(FUNC_PUSH, 1, 0, 0, 32'h1));
    add_req(mk_req(FUNC_PUSH, 1, 0, 1, 32'h2));
    add_req(mk_req(FUNC_MERGE, 0, 1, 1, 0));           // reversed
    add_req(mk_req(FUNC_MERGE, 0, 2, 0, 0));           // empty source
    add_req(mk_req(FUNC_MERGE, 1023, 0, 0, 0));        // in order
    add_req(mk_req(FUNC_POP, 1023, 0, 1, 0));
    add_req(mk_req(FUNC_POP, 1023, 0, 0, 0));
    add_req(mk_req(FUNC_MERGE, 1023, 1023, 1, 0));     // into itself
    add_req(mk_req(FUNC_POP, 1023, 0, 1, 0));
    add_req(mk_req(FUNC_PUSH, 5, 0, 0, 32'h1234_5678));
    add_req(mk_req(FUNC_CLEAR, 777, 333, 1, 32'hdead_beef));
    add_req(mk_req(FUNC_POP, 5, 0, 0, 0));
    drain();

    // Bad queue numbers with a small count, and a count of zero.
    write_qcount(3);
    add_req(mk_req(FUNC_PUSH, 3, 0, 0, 32'h55));
    add_req(mk_req(FUNC_MERGE, 0, 3, 0, 0));
    add_req(mk_req(FUNC_POP, 2, 0, 1, 0));
    add_req(mk_req(FUNC_PUSH, 2, 0, 1, 32'haa));
    drain();
    write_qcount(0);
    add_req(mk_req(FUNC_POP, 0, 0, 0, 0));
    add_req(mk_req(FUNC_CLEAR, 0, 0, 0, 0));
    drain();

    // Count above the queue total acts as the total.
    write_qcount(2047);
    run_random(200, 8);
    write_qcount(1);
    run_random(100, 2);
    write_qcount(1024);
    // A pop from the back and a clear with the full queue count.
    add_req(mk_req(FUNC_POP, 2, 0, 1, 0));
    add_req(mk_req(FUNC_CLEAR, 0, 0, 0, 0));
    drain();
    write_qcount(16);
    run_random(300, 20);
    // Final stretch without idling on either side.
    quiet = 1'b1;
    write_qcount(1024);
    run_random(200, 6);

    $display("items in=%0d out=%0d, pops with data=%0d, pool full=%0d, bad queue=%0d",
             accepted_in, accepted_out, n_pop_ok, n_full, n_badq);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("errors: %0d", errors);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mdpm_pkg.sv
design/mdpm_ctrl.sv
design/mdpm_datapath.sv
design/multi_deque_pool_manager.sv
bench/tb_top.sv
